[sv/lssp_pkg.sv]
// Shared types and constants for the link-state shortest path block.
`default_nettype none
package lssp_pkg;
	localparam int NODES = 16;
	localparam int WEIGHT_BITS = 16;
	localparam int NODE_W = $clog2(NODES);
	localparam int CNT_W = $clog2(NODES + 1);
	localparam int COST_W = 21;
	localparam int LINKS = NODES * NODES;
	localparam int LINK_AW = $clog2(LINKS);
	localparam logic [COST_W-1:0] COST_INF = '1;
	localparam logic [19:0] COST_SAT = 20'hFFFFF;

	typedef enum logic [1:0] {
		KIND_SET = 2'd0,
		KIND_REMOVE = 2'd1,
		KIND_COMPUTE = 2'd2,
		KIND_NONE = 2'd3
	} kind_t;

	typedef enum logic [0:0] {
		CFG_NODE_COUNT = 1'b0,
		CFG_SKIP_WEIGHT = 1'b1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SET_RD,
		ST_SET_WR,
		ST_SCAN,
		ST_RELAX,
		ST_HOP,
		ST_EMIT
	} state_t;

	// Command from the sequencer to the cell row.
	typedef struct packed {
		logic init;
		logic [NODE_W-1:0] src;
		logic relax;
		logic [NODE_W-1:0] u;
		logic [COST_W-1:0] u_cost;
		logic [WEIGHT_BITS-1:0] w;
		logic [NODE_W-1:0] v;
		logic mark;
	} cell_cmd_t;
endpackage
`default_nettype wire

[sv/link_state_shortest_path.sv]
// Link-state shortest path engine: link table, sequencer and cell row.
// Usage:
//  s_axis carries commands: set link, remove link, compute routes.
//  m_axis carries one routing entry per destination after a compute,
//  destinations 0..n-1 in order, tlast on the last one.
//  cfg_we/cfg_idx/cfg_data write node_count (0) and skip_weight (1).
// Throughput: one item is processed at a time. After acceptance a set keeps
//  s_tready low through its read of the old weight and its writes of both
//  directions, a remove through the writes alone. A compute runs up to n
//  rounds of a scan and a relax pass over the n nodes, one final scan, then
//  per destination a predecessor walk and its emit beat; the emit beats
//  also wait on the receiver.
// The min search moves one cell per cycle along the row, so a scan waits
//  until the value has passed every cell and the end of the row is settled.
// Reset: the 256-entry link memory is cleared by a sweep of every entry;
//  s_tready stays low during it. Scratch cells clear at once.
// Stall: with m_tready low the output beat holds and the engine waits in
//  its emit state; the last beat may still wait while the next item is taken.
`default_nettype none
module link_state_shortest_path (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	// kind[1:0], node_a[5:2], node_b[9:6], weight[25:10], zero pad to 32
	input wire logic [31:0] s_tdata,
	output logic m_tvalid,
	input wire logic m_tready,
	// dest_node[3:0], next_hop[7:4], path_cost[27:8], zero pad to 32
	output logic [31:0] m_tdata,
	// reachable
	output logic m_tuser,
	output logic m_tlast,
	input wire logic cfg_we,
	input wire logic [0:0] cfg_idx,
	input wire logic [15:0] cfg_data
);
	import lssp_pkg::*;

	logic [4:0] node_count_q;
	logic [15:0] skip_q;
	logic [CNT_W-1:0] n_act;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= 5'd16;
			skip_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_NODE_COUNT: node_count_q <= cfg_data[4:0];
				CFG_SKIP_WEIGHT: skip_q <= cfg_data;
				default: ;
			endcase
		end
	end
	always_comb begin
		if (node_count_q == '0) n_act = CNT_W'(1);
		else if (32'(node_count_q) > NODES) n_act = CNT_W'(NODES);
		else n_act = CNT_W'(node_count_q);
	end

	// link memory
	logic [WEIGHT_BITS-1:0] mem [LINKS];
	logic mem_we;
	logic [LINK_AW-1:0] mem_wa, mem_ra;
	logic [WEIGHT_BITS-1:0] mem_wd, mem_rd_q;
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		mem_rd_q <= mem[mem_ra];
	end

	state_t st_q, st_d;
	logic [LINK_AW:0] clr_q;
	logic clearing;
	assign clearing = !clr_q[LINK_AW];

	logic [NODE_W-1:0] a_q, b_q, u_q, v_q, d_q, cur_q;
	logic [WEIGHT_BITS-1:0] w_q;
	logic wr_second_q;
	logic rd_pend_q;
	logic [CNT_W-1:0] rnd_q, hop_q;
	logic [CNT_W-1:0] scan_q;
	logic scan_ready;
	// chain end is settled once every cell has handed on its value
	assign scan_ready = (scan_q == CNT_W'(NODES));

	logic [1:0] in_kind;
	logic [NODE_W-1:0] in_a, in_b;
	logic [WEIGHT_BITS-1:0] in_w;
	assign in_kind = s_tdata[1:0];
	assign in_a = s_tdata[5:2];
	assign in_b = s_tdata[9:6];
	assign in_w = s_tdata[10 +: WEIGHT_BITS];

	logic acc;
	assign s_tready = (st_q == ST_IDLE) && !clearing;
	assign acc = s_tvalid && s_tready;

	// cell row
	cell_cmd_t cmd;
	logic [NODES:0] ch_v;
	logic [COST_W-1:0] ch_c [NODES+1];
	logic [NODE_W-1:0] ch_n [NODES+1];
	logic [COST_W-1:0] cell_cost [NODES];
	logic [NODE_W:0] cell_pred [NODES];
	assign ch_v[0] = 1'b0;
	assign ch_c[0] = '0;
	assign ch_n[0] = '0;
	for (genvar g = 0; g < NODES; g++) begin : g_cell
		lssp_cell u_cell (
			.clk, .arst_n,
			.my_id(NODE_W'(g)), .cmd,
			.in_valid(ch_v[g]), .in_cost(ch_c[g]), .in_node(ch_n[g]),
			.in_use(CNT_W'(g) < n_act),
			.out_valid(ch_v[g+1]), .out_cost(ch_c[g+1]), .out_node(ch_n[g+1]),
			.cost(cell_cost[g]), .pred(cell_pred[g])
		);
	end

	logic in_ok, relax_now;
	assign in_ok = ({1'b0, in_a} < n_act) && ({1'b0, in_b} < n_act);
	assign relax_now = (st_q == ST_RELAX) && rd_pend_q;

	always_comb begin
		cmd = '0;
		cmd.init = acc && in_kind == KIND_COMPUTE && ({1'b0, in_a} < n_act);
		cmd.src = in_a;
		cmd.mark = (st_q == ST_SCAN) && scan_ready && ch_v[NODES];
		cmd.u = (st_q == ST_SCAN) ? ch_n[NODES] : u_q;
		cmd.u_cost = cell_cost[u_q];
		cmd.relax = relax_now;
		cmd.w = mem_rd_q;
		cmd.v = v_q;
	end

	logic [NODE_W:0] pc;
	assign pc = cell_pred[cur_q];
	logic relax_end;
	assign relax_end = rd_pend_q && ({1'b0, v_q} == n_act - 1'b1);
	logic [NODE_W-1:0] v_next_rd;
	// read address leads v: v takes its value in the cycle after
	logic [NODE_W-1:0] rd_v_q;

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE:
				if (acc) begin
					case (in_kind)
						KIND_SET: if (in_ok && in_w != '0) st_d = ST_SET_RD;
						KIND_REMOVE: if (in_ok) st_d = ST_SET_WR;
						KIND_COMPUTE: if ({1'b0, in_a} < n_act) st_d = ST_SCAN;
						default: ;
					endcase
				end
			ST_SET_RD: if (rd_pend_q) st_d = ST_SET_WR;
			ST_SET_WR: if (wr_second_q) st_d = ST_IDLE;
			ST_SCAN:
				if (scan_ready) begin
					if (!ch_v[NODES] || rnd_q == n_act) st_d = ST_HOP;
					else st_d = ST_RELAX;
				end
			ST_RELAX: if (relax_end) st_d = ST_SCAN;
			ST_HOP:
				if ({1'b0, d_q} == {1'b0, a_q} || pc[NODE_W] || pc[NODE_W-1:0] == a_q
				    || hop_q == CNT_W'(NODES)) st_d = ST_EMIT;
			ST_EMIT:
				if (m_tready || !m_tvalid) begin
					if ({1'b0, d_q} == n_act - 1'b1) st_d = ST_IDLE;
					else st_d = ST_HOP;
				end
			default: st_d = ST_IDLE;
		endcase
	end
	assign v_next_rd = rd_v_q + 1'b1;

	always_comb begin
		mem_we = 1'b0;
		mem_wa = {a_q, b_q};
		mem_wd = w_q;
		mem_ra = {u_q, rd_v_q};
		if (clearing) begin
			mem_we = 1'b1;
			mem_wa = clr_q[LINK_AW-1:0];
			mem_wd = '0;
		end else if (st_q == ST_SET_WR) begin
			mem_we = 1'b1;
			mem_wa = wr_second_q ? {b_q, a_q} : {a_q, b_q};
		end
		if (st_q == ST_IDLE) mem_ra = {in_a, in_b};
		if (st_q == ST_SET_RD) mem_ra = {a_q, b_q};
		if (st_q == ST_SCAN) mem_ra = {ch_n[NODES], {NODE_W{1'b0}}};
	end

	logic emit_fire;
	assign emit_fire = (st_q == ST_EMIT) && (m_tready || !m_tvalid);

	logic [3:0] emit_hop;
	logic [19:0] emit_cost;
	assign emit_hop = (cell_cost[d_q] == COST_INF) ? 4'd0
		: ((d_q == a_q) ? 4'(a_q)
		: ((pc[NODE_W] || hop_q == CNT_W'(NODES)) ? 4'(a_q) : 4'(cur_q)));
	assign emit_cost = (cell_cost[d_q] == COST_INF) ? 20'd0
		: ((cell_cost[d_q] > {1'b0, COST_SAT}) ? COST_SAT : cell_cost[d_q][19:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			clr_q <= '0;
			m_tvalid <= 1'b0;
			rd_pend_q <= 1'b0;
			wr_second_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (clearing) clr_q <= clr_q + 1'b1;
			m_tvalid <= emit_fire || (m_tvalid && !m_tready);
			rd_pend_q <= (st_q == ST_SET_RD) || (st_q == ST_SCAN)
				|| (st_q == ST_RELAX && !relax_end);
			wr_second_q <= (st_q == ST_SET_WR) && !wr_second_q;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			a_q <= in_a;
			b_q <= in_b;
			// a remove writes zero into both directions
			w_q <= (in_kind == KIND_REMOVE) ? '0 : in_w;
			rnd_q <= '0;
			d_q <= '0;
			cur_q <= '0;
			hop_q <= '0;
			scan_q <= '0;
		end
		// skip rule: drop the write by turning it into a rewrite of the old value
		if (st_q == ST_SET_RD && rd_pend_q && mem_rd_q == '0 && skip_q != '0
		    && w_q == skip_q)
			w_q <= '0;
		if (st_q == ST_SCAN) begin
			scan_q <= scan_ready ? '0 : scan_q + 1'b1;
			if (scan_ready) begin
				u_q <= ch_n[NODES];
				rd_v_q <= '0;
				v_q <= '0;
				rnd_q <= rnd_q + 1'b1;
				if (st_d == ST_HOP) begin
					cur_q <= '0;
					hop_q <= '0;
				end
			end
		end
		if (st_q == ST_RELAX) begin
			v_q <= rd_v_q;
			rd_v_q <= v_next_rd;
		end
		if (st_q == ST_HOP && st_d == ST_HOP) begin
			cur_q <= pc[NODE_W-1:0];
			hop_q <= hop_q + 1'b1;
		end
		if (emit_fire) begin
			m_tdata <= {4'd0, emit_cost, emit_hop, 4'(d_q)};
			m_tuser <= cell_cost[d_q] != COST_INF;
			m_tlast <= {1'b0, d_q} == n_act - 1'b1;
			d_q <= d_q + 1'b1;
			cur_q <= d_q + 1'b1;
			hop_q <= '0;
		end
	end

`ifndef SYNTHESIS
	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !s_tready) else $error("accept during clear");
	a_emit_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid) else $error("beat dropped");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready || st_q == ST_IDLE) else $error("busy state");
`endif
endmodule
`default_nettype wire

[sv/lssp_cell.sv]
// One router cell: holds best cost, predecessor and done mark for one node.
`default_nettype none
module lssp_cell (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic [lssp_pkg::NODE_W-1:0] my_id,
	input wire lssp_pkg::cell_cmd_t cmd,
	// min-scan chain in from lower neighbor
	input wire logic in_valid,
	input wire logic [lssp_pkg::COST_W-1:0] in_cost,
	input wire logic [lssp_pkg::NODE_W-1:0] in_node,
	input wire logic in_use,
	output logic out_valid,
	output logic [lssp_pkg::COST_W-1:0] out_cost,
	output logic [lssp_pkg::NODE_W-1:0] out_node,
	output logic [lssp_pkg::COST_W-1:0] cost,
	output logic [lssp_pkg::NODE_W:0] pred
);
	import lssp_pkg::*;
	logic [COST_W-1:0] cost_q;
	logic [NODE_W:0] pred_q;
	logic done_q;
	logic cand, take;
	logic [COST_W:0] sum;
	logic [COST_W-1:0] c;
	logic valid_s1;
	logic [COST_W-1:0] cost_s1;
	logic [NODE_W-1:0] node_s1;

	assign cost = cost_q;
	assign pred = pred_q;

	// chain: keep first (lowest id) strict minimum, one cell per cycle
	assign cand = in_use && !done_q && cost_q != COST_INF;
	assign take = cand && (!in_valid || cost_q < in_cost);
	assign out_valid = valid_s1;
	assign out_cost = cost_s1;
	assign out_node = node_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			cost_s1 <= '0;
			node_s1 <= '0;
		end else begin
			valid_s1 <= in_valid || cand;
			cost_s1 <= take ? cost_q : in_cost;
			node_s1 <= take ? my_id : in_node;
		end
	end

	assign sum = {1'b0, cmd.u_cost} + {{(COST_W-WEIGHT_BITS+1){1'b0}}, cmd.w};
	assign c = sum[COST_W] ? COST_INF - 1'b1 : sum[COST_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cost_q <= '0;
			pred_q <= '0;
			done_q <= 1'b0;
		end else if (cmd.init) begin
			cost_q <= (cmd.src == my_id) ? '0 : COST_INF;
			pred_q <= {1'b1, {NODE_W{1'b0}}};
			done_q <= 1'b0;
		end else begin
			if (cmd.mark && cmd.u == my_id)
				done_q <= 1'b1;
			if (cmd.relax && cmd.v == my_id && cmd.w != '0 && !done_q) begin
				if (c < cost_q) begin
					cost_q <= c;
					pred_q <= {1'b0, cmd.u};
				end else if (c == cost_q && {1'b0, cmd.u} < pred_q) begin
					pred_q <= {1'b0, cmd.u};
				end
			end
		end
	end
endmodule
`default_nettype wire
